[hw/rtl/mfld_pkg.sv]
// Shared types and constants for the monochrome frame buffer line drawer.
// Holds command codes, controller states and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfld_pkg;

   // Default panel geometry: columns and eight-row pages.
   localparam int PANEL_WIDTH_DEF = 84;
   localparam int PANEL_PAGES_DEF = 6;

   // Fixed field widths of the request and response words.
   localparam int COORD_W     = 7;
   localparam int CMD_W       = 2;
   localparam int RADDR_W     = 9;
   localparam int DATA_W      = 8;
   localparam int COUNT_W     = 8;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   // Command codes carried in the request tuser field.
   typedef enum logic [CMD_W-1:0] {
      CMD_DRAW  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PIX,
      ST_WR,
      ST_CLEAR,
      ST_FETCH,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic pix_rd;
      logic pix_wr;
      logic step;
      logic clr_wr;
      logic fetch;
      logic res_load;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_panel;
      logic line_last;
      logic clr_last;
   } stat_type;

endpackage

`default_nettype wire

[hw/rtl/mfld_ctrl.sv]
// Controller state machine for the frame buffer line drawer.
// Sequences clear sweeps, pixel read-modify-write and result hand-off.
// Depends on mfld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfld_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [mfld_pkg::CMD_W-1:0]  req_cmd,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output mfld_pkg::ctrl_type               ctrl,
   input  wire mfld_pkg::stat_type          stat
);

   mfld_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && (state_ff == mfld_pkg::ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfld_pkg::ST_INIT: begin
            if (stat.clr_last) state_in = mfld_pkg::ST_IDLE;
         end
         mfld_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  mfld_pkg::CMD_DRAW:  state_in = mfld_pkg::ST_PIX;
                  mfld_pkg::CMD_CLEAR: state_in = mfld_pkg::ST_CLEAR;
                  mfld_pkg::CMD_READ:  state_in = mfld_pkg::ST_FETCH;
                  default:             state_in = mfld_pkg::ST_DONE;
               endcase
            end
         end
         mfld_pkg::ST_PIX: begin
            if (stat.in_panel) state_in = mfld_pkg::ST_WR;
            else if (stat.line_last) state_in = mfld_pkg::ST_DONE;
         end
         mfld_pkg::ST_WR: begin
            state_in = stat.line_last ? mfld_pkg::ST_DONE : mfld_pkg::ST_PIX;
         end
         mfld_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = mfld_pkg::ST_DONE;
         end
         mfld_pkg::ST_FETCH: begin
            state_in = mfld_pkg::ST_DONE;
         end
         mfld_pkg::ST_DONE: begin
            if (out_free) state_in = mfld_pkg::ST_IDLE;
         end
         default: state_in = mfld_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands and input ready.
   always_comb begin
      ctrl       = '0;
      req_tready = 1'b0;
      case (state_ff)
         mfld_pkg::ST_INIT,
         mfld_pkg::ST_CLEAR: ctrl.clr_wr = 1'b1;
         mfld_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ctrl.load  = req_tvalid;
         end
         mfld_pkg::ST_PIX: begin
            if (stat.in_panel) ctrl.pix_rd = 1'b1;
            else ctrl.step = !stat.line_last;
         end
         mfld_pkg::ST_WR: begin
            ctrl.pix_wr = 1'b1;
            ctrl.step   = !stat.line_last;
         end
         mfld_pkg::ST_FETCH: ctrl.fetch = 1'b1;
         mfld_pkg::ST_DONE: ctrl.res_load = out_free;
         default: ctrl = '0;
      endcase
   end

   // Result valid flag: set when a result is loaded, dropped when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.res_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfld_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

[hw/rtl/mfld_datapath.sv]
// Datapath for the frame buffer line drawer: frame memory, line stepper,
// clear counter and result registers. Depends on mfld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfld_datapath #(
   parameter int PANEL_WIDTH = mfld_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_PAGES = mfld_pkg::PANEL_PAGES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mfld_pkg::ctrl_type            ctrl,
   output mfld_pkg::stat_type                 stat,
   input  wire logic [mfld_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [mfld_pkg::COORD_W-1:0]  req_start_x,
   input  wire logic [mfld_pkg::COORD_W-1:0]  req_start_y,
   input  wire logic [mfld_pkg::COORD_W-1:0]  req_end_x,
   input  wire logic [mfld_pkg::COORD_W-1:0]  req_end_y,
   input  wire logic                          req_pixel_on,
   input  wire logic [mfld_pkg::RADDR_W-1:0]  req_read_address,
   output logic [mfld_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [mfld_pkg::COUNT_W-1:0]       rsp_pixels_drawn
);

   localparam int STORE_BYTES = PANEL_WIDTH * PANEL_PAGES;
   localparam int PANEL_ROWS  = PANEL_PAGES * 8;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int CW          = mfld_pkg::COORD_W;
   localparam int DW          = mfld_pkg::DATA_W;

   // Frame memory with registered read data.
   logic [DW-1:0]     frame_mem [STORE_BYTES];
   logic [DW-1:0]     mem_q_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [DW-1:0]     mem_wd;

   // Line state.
   logic [CW-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW-1:0] major_ff, major_in, minor_ff, minor_in;
   logic [CW-1:0] rem_ff, rem_in, left_ff, left_in;
   logic          x_up_ff, x_up_in, y_up_ff, y_up_in;
   logic          x_major_ff, x_major_in, on_ff, on_in;
   logic [mfld_pkg::COUNT_W-1:0] count_ff, count_in;

   // Command and read address of the current item.
   logic [mfld_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [ADDR_W-1:0]          raddr_ff, raddr_in;
   logic                       raddr_ok_ff, raddr_ok_in;

   // Clear sweep counter.
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   // Result registers.
   logic [DW-1:0]                rd_data_ff, rd_data_in;
   logic [mfld_pkg::COUNT_W-1:0] drawn_ff, drawn_in;

   // Setup values derived from the request word.
   logic          ld_x_up, ld_y_up, ld_x_major;
   logic [CW-1:0] ld_adx, ld_ady;

   // Step values.
   logic [CW:0]       rem_sum;
   logic              wrap, mv_x, mv_y;
   logic [ADDR_W-1:0] pix_addr;
   logic [DW-1:0]     pix_mask, pix_byte;

   // Line direction and extents from the endpoints.
   always_comb begin
      ld_x_up    = req_end_x >= req_start_x;
      ld_y_up    = req_end_y >= req_start_y;
      ld_adx     = ld_x_up ? CW'(req_end_x - req_start_x) : CW'(req_start_x - req_end_x);
      ld_ady     = ld_y_up ? CW'(req_end_y - req_start_y) : CW'(req_start_y - req_end_y);
      ld_x_major = ld_adx >= ld_ady;
   end

   // Minor-axis remainder: advance the minor coordinate when it wraps.
   always_comb begin
      rem_sum = {1'b0, rem_ff} + {1'b0, minor_ff};
      wrap    = rem_sum >= {1'b0, major_ff};
      mv_x    = x_major_ff || wrap;
      mv_y    = !x_major_ff || wrap;
   end

   // Pixel position in the store and the modified byte.
   always_comb begin
      stat.in_panel  = ({1'b0, cur_x_ff} < (CW+1)'(PANEL_WIDTH)) &&
                       ({1'b0, cur_y_ff} < (CW+1)'(PANEL_ROWS));
      stat.line_last = left_ff == '0;
      stat.clr_last  = clr_cnt_ff == ADDR_W'(STORE_BYTES - 1);
      pix_addr = ADDR_W'(ADDR_W'(cur_y_ff[5:3]) * ADDR_W'(PANEL_WIDTH)
                         + ADDR_W'(cur_x_ff));
      pix_mask = DW'(1) << cur_y_ff[2:0];
      pix_byte = on_ff ? (mem_q_ff | pix_mask) : (mem_q_ff & ~pix_mask);
   end

   // Memory port selection.
   always_comb begin
      mem_we = ctrl.clr_wr || ctrl.pix_wr;
      mem_wa = ctrl.clr_wr ? clr_cnt_ff : pix_addr;
      mem_wd = ctrl.clr_wr ? '0 : pix_byte;
      mem_re = ctrl.pix_rd || ctrl.fetch;
      mem_ra = ctrl.fetch ? raddr_ff : pix_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) frame_mem[mem_wa] <= mem_wd;
      if (mem_re) mem_q_ff <= frame_mem[mem_ra];
   end

   // Next values of the working registers.
   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      major_in    = major_ff;
      minor_in    = minor_ff;
      rem_in      = rem_ff;
      left_in     = left_ff;
      x_up_in     = x_up_ff;
      y_up_in     = y_up_ff;
      x_major_in  = x_major_ff;
      on_in       = on_ff;
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      raddr_in    = raddr_ff;
      raddr_ok_in = raddr_ok_ff;
      clr_cnt_in  = clr_cnt_ff;
      rd_data_in  = rd_data_ff;
      drawn_in    = drawn_ff;

      if (ctrl.load) begin
         cur_x_in    = req_start_x;
         cur_y_in    = req_start_y;
         x_up_in     = ld_x_up;
         y_up_in     = ld_y_up;
         x_major_in  = ld_x_major;
         major_in    = ld_x_major ? ld_adx : ld_ady;
         minor_in    = ld_x_major ? ld_ady : ld_adx;
         left_in     = ld_x_major ? ld_adx : ld_ady;
         rem_in      = '0;
         on_in       = req_pixel_on;
         count_in    = '0;
         cmd_in      = req_cmd;
         raddr_in    = ADDR_W'(req_read_address);
         raddr_ok_in = {2'b00, req_read_address} < (mfld_pkg::RADDR_W+2)'(STORE_BYTES);
      end

      if (ctrl.step) begin
         if (mv_x) cur_x_in = x_up_ff ? CW'(cur_x_ff + 1'b1) : CW'(cur_x_ff - 1'b1);
         if (mv_y) cur_y_in = y_up_ff ? CW'(cur_y_ff + 1'b1) : CW'(cur_y_ff - 1'b1);
         rem_in  = wrap ? CW'(rem_sum - {1'b0, major_ff}) : CW'(rem_sum);
         left_in = CW'(left_ff - 1'b1);
      end

      if (ctrl.pix_wr) count_in = count_ff + 1'b1;

      if (ctrl.clr_wr) clr_cnt_in = stat.clr_last ? '0 : ADDR_W'(clr_cnt_ff + 1'b1);

      if (ctrl.res_load) begin
         rd_data_in = (cmd_ff == mfld_pkg::CMD_READ && raddr_ok_ff) ? mem_q_ff : '0;
         drawn_in   = count_ff;
      end
   end

   // Clear counter is control state; the rest are payload.
   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else clr_cnt_ff <= clr_cnt_in;
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      major_ff    <= major_in;
      minor_ff    <= minor_in;
      rem_ff      <= rem_in;
      left_ff     <= left_in;
      x_up_ff     <= x_up_in;
      y_up_ff     <= y_up_in;
      x_major_ff  <= x_major_in;
      on_ff       <= on_in;
      count_ff    <= count_in;
      cmd_ff      <= cmd_in;
      raddr_ff    <= raddr_in;
      raddr_ok_ff <= raddr_ok_in;
      rd_data_ff  <= rd_data_in;
      drawn_ff    <= drawn_in;
   end

   assign rsp_read_data    = rd_data_ff;
   assign rsp_pixels_drawn = drawn_ff;

endmodule

`default_nettype wire

[hw/rtl/mono_framebuffer_line_draw.sv]
// Top level of the monochrome frame buffer line drawer.
// Unpacks the request word and joins mfld_ctrl and mfld_datapath; uses mfld_pkg.
//
//   Channel  Direction  Contents
//   req_     in         tuser: cmd; tdata: endpoints, pixel_on, read_address
//   rsp_     out        tdata: read_data, pixels_drawn
//
// A draw visits the longer axis length plus one pixels (at most 128), reading and
// then writing each on-panel pixel and only stepping past each off-panel pixel.
// A clear writes zero to all PANEL_WIDTH*PANEL_PAGES bytes (504); a read fetches one byte.
// After reset the frame memory is swept to zero, all 504 bytes, before input is taken.
// The block has a single memory port pair; one word is worked at a time,
// and the next word is taken while a finished result waits at the output.
`timescale 1ns / 1ps
`default_nettype none

module mono_framebuffer_line_draw #(
   parameter int PANEL_WIDTH = mfld_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_PAGES = mfld_pkg::PANEL_PAGES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [6:0] start_x, [13:7] start_y, [20:14] end_x, [27:21] end_y,
   // [28] pixel_on, [37:29] read_address, [39:38] zero
   input  wire logic [mfld_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] cmd
   input  wire logic [mfld_pkg::CMD_W-1:0]           req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [7:0] read_data, [15:8] pixels_drawn
   output logic [mfld_pkg::RSP_TDATA_W-1:0]          rsp_tdata
);

   mfld_pkg::ctrl_type ctrl;
   mfld_pkg::stat_type stat;
   logic [mfld_pkg::DATA_W-1:0]  read_data;
   logic [mfld_pkg::COUNT_W-1:0] pixels_drawn;

   mfld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl),
      .stat       (stat)
   );

   mfld_datapath #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_PAGES (PANEL_PAGES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_cmd          (req_tuser),
      .req_start_x      (req_tdata[6:0]),
      .req_start_y      (req_tdata[13:7]),
      .req_end_x        (req_tdata[20:14]),
      .req_end_y        (req_tdata[27:21]),
      .req_pixel_on     (req_tdata[28]),
      .req_read_address (req_tdata[37:29]),
      .rsp_read_data    (read_data),
      .rsp_pixels_drawn (pixels_drawn)
   );

   assign rsp_tdata = {pixels_drawn, read_data};

`ifndef SYNTHESIS
   // A draw never reports more pixels than a line can touch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:8] <= 8'd128))
      else $error("pixel count above line length");

   // A result carries either read data or a pixel count, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == 8'd0 || rsp_tdata[15:8] == 8'd0))
      else $error("read data and pixel count both nonzero");

   // Input is not ready as reset falls, while the memory is swept.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("input taken before reset clear sweep");

   // Memory clear writes never coincide with pixel accesses or input loads.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.clr_wr |-> !(ctrl.pix_rd || ctrl.pix_wr || ctrl.load))
      else $error("clear sweep overlaps other work");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for mono_framebuffer_line_draw.
// Drives draw, clear, read and unused-code words, keeps its own shadow copy of the frame store,
// and checks every response word. Depends on mfld_pkg and the top level RTL only.
`timescale 1ns / 1ps

module testbench;
   import mfld_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 6;
   localparam int PANEL_W        = PANEL_WIDTH_DEF;
   localparam int PANEL_ROWS     = PANEL_PAGES_DEF * 8;
   localparam int STORE_BYTES    = PANEL_W * PANEL_PAGES_DEF;
   localparam int COORD_MAX      = (1 << COORD_W) - 1;
   localparam int RADDR_MAX      = (1 << RADDR_W) - 1;
   localparam int RANDOM_WORDS   = 1030;
   localparam int PRESSURE_WORDS = 30;
   localparam int PRESSURE_HOLD  = 2000;
   localparam int DRAIN_CYCLES   = 520;
   // The longest quiet stretch in a correct run is a long receiver hold after
   // which a clear still has to finish, plus a long sender gap.
   localparam int IDLE_LIMIT     = 20000;

   // The one command code that the package leaves unnamed changes nothing and answers with zeros.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
      logic               pixel_on;
      logic [RADDR_W-1:0] read_address;
   } line_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic [COUNT_W-1:0] pixels_drawn;
   } line_rsp_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]       req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow of the frame store and the responses still owed by the block.
   logic [DATA_W-1:0] shadow_frame [STORE_BYTES];
   line_rsp_type      pending_responses [$];

   int errors          = 0;
   int idle_cycles     = 0;
   int burst_left      = 0;
   int rx_hold_request = 0;
   int last_line_addr  = 0;
   bit gaps_off        = 1'b0;

   mono_framebuffer_line_draw dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Sets or clears one pixel of the shadow; returns 1 when it lies on the panel.
   function automatic int plot_shadow_pixel(int x, int y, logic on);
      int addr;
      if (x < 0 || y < 0 || x >= PANEL_W || y >= PANEL_ROWS) return 0;
      addr = (y / 8) * PANEL_W + x;
      shadow_frame[addr][y % 8] = on;
      return 1;
   endfunction

   // Walks the longer axis; the minor coordinate is truncated minor*k/major.
   function automatic int rasterize_line(int x0, int y0, int x1, int y1, logic on);
      int sx;
      int sy;
      int adx;
      int ady;
      int count;
      sx    = (x1 >= x0) ? 1 : -1;
      sy    = (y1 >= y0) ? 1 : -1;
      adx   = (x1 >= x0) ? x1 - x0 : x0 - x1;
      ady   = (y1 >= y0) ? y1 - y0 : y0 - y1;
      count = 0;
      if (adx >= ady) begin
         for (int k = 0; k < adx; k++)
            count += plot_shadow_pixel(x0 + sx * k, y0 + sy * ((ady * k) / adx), on);
      end else begin
         for (int k = 0; k < ady; k++)
            count += plot_shadow_pixel(x0 + sx * ((adx * k) / ady), y0 + sy * k, on);
      end
      count += plot_shadow_pixel(x1, y1, on);
      return count;
   endfunction

   // Applies one command word to the shadow and returns the response it should give.
   function automatic line_rsp_type predict_response(line_cmd_type c);
      line_rsp_type r;
      r = '0;
      case (c.cmd)
         CMD_DRAW: begin
            r.pixels_drawn = COUNT_W'(rasterize_line(int'(c.x0), int'(c.y0), int'(c.x1),
                                                     int'(c.y1), c.pixel_on));
         end
         CMD_CLEAR: begin
            foreach (shadow_frame[i]) shadow_frame[i] = '0;
         end
         CMD_READ: begin
            if (c.read_address < STORE_BYTES) r.read_data = shadow_frame[c.read_address];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Offers one word in bursts with random gaps and records its response once taken.
   task automatic send_word(line_cmd_type c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!gaps_off) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 400) : $urandom_range(1, 8);
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = c.cmd;
      req_tdata  = {2'b00, c.read_address, c.pixel_on, c.y1, c.x1, c.y0, c.x0};
      do @(posedge clock); while (!req_tready);
      pending_responses.push_back(predict_response(c));
      if (c.cmd == CMD_DRAW && c.x1 < PANEL_W && c.y1 < PANEL_ROWS)
         last_line_addr = (int'(c.y1) / 8) * PANEL_W + int'(c.x1);
   endtask

   task automatic issue(logic [CMD_W-1:0] cmd, int x0, int y0, int x1, int y1, logic on,
                        int addr);
      line_cmd_type c;
      c.cmd          = cmd;
      c.x0           = COORD_W'(x0);
      c.y0           = COORD_W'(y0);
      c.x1           = COORD_W'(x1);
      c.y1           = COORD_W'(y1);
      c.pixel_on     = on;
      c.read_address = RADDR_W'(addr);
      send_word(c);
   endtask

   task automatic read_byte(int addr);
      issue(CMD_READ, 0, 0, 0, 0, 1'b0, addr);
   endtask

   // Mostly lines on the panel and reads in the store, many near what was just drawn, some of it off the edges.
   function automatic line_cmd_type random_word();
      line_cmd_type c;
      int pick;
      int lo;
      int hi;
      int near_addr;
      c.cmd          = CMD_UNUSED;
      c.x0           = COORD_W'($urandom_range(0, COORD_MAX));
      c.y0           = COORD_W'($urandom_range(0, COORD_MAX));
      c.x1           = COORD_W'($urandom_range(0, COORD_MAX));
      c.y1           = COORD_W'($urandom_range(0, COORD_MAX));
      c.pixel_on     = 1'($urandom_range(0, 1));
      c.read_address = RADDR_W'($urandom_range(0, RADDR_MAX));
      pick = $urandom_range(0, 99);
      if (pick < 46) begin
         c.cmd      = CMD_DRAW;
         c.pixel_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            c.x0 = COORD_W'($urandom_range(0, PANEL_W - 1));
            c.y0 = COORD_W'($urandom_range(0, PANEL_ROWS - 1));
            c.x1 = COORD_W'($urandom_range(0, PANEL_W - 1));
            c.y1 = COORD_W'($urandom_range(0, PANEL_ROWS - 1));
         end
         // Short lines and single points around the start.
         if ($urandom_range(0, 4) == 0) begin
            lo   = (c.x0 > 4) ? int'(c.x0) - 4 : 0;
            hi   = (c.x0 < COORD_MAX - 4) ? int'(c.x0) + 4 : COORD_MAX;
            c.x1 = COORD_W'($urandom_range(lo, hi));
            lo   = (c.y0 > 4) ? int'(c.y0) - 4 : 0;
            hi   = (c.y0 < COORD_MAX - 4) ? int'(c.y0) + 4 : COORD_MAX;
            c.y1 = COORD_W'($urandom_range(lo, hi));
         end
      end else if (pick < 92) begin
         c.cmd = CMD_READ;
         if ($urandom_range(0, 9) == 0) begin
            c.read_address = RADDR_W'($urandom_range(0, RADDR_MAX));
         end else if ($urandom_range(0, 1) == 0) begin
            near_addr = last_line_addr + int'($urandom_range(0, 4)) - 2;
            if (near_addr < 0) near_addr = 0;
            if (near_addr >= STORE_BYTES) near_addr = STORE_BYTES - 1;
            c.read_address = RADDR_W'(near_addr);
         end else begin
            c.read_address = RADDR_W'($urandom_range(0, STORE_BYTES - 1));
         end
      end else if (pick < 95) begin
         c.cmd = CMD_CLEAR;
      end
      return c;
   endfunction

   // The store must read as zero straight after reset.
   task automatic test_reset_contents();
      read_byte(0);
      read_byte(STORE_BYTES - 1);
   endtask

   // Corners, clipping at both edges, several directions of travel, and the odd commands.
   task automatic test_directed_lines();
      line_cmd_type junk;
      issue(CMD_DRAW, 0, 0, 0, 0, 1'b1, 0);
      issue(CMD_DRAW, PANEL_W - 1, PANEL_ROWS - 1, PANEL_W - 1, PANEL_ROWS - 1, 1'b1, 0);
      read_byte(0);
      read_byte(STORE_BYTES - 1);
      issue(CMD_DRAW, PANEL_W, PANEL_ROWS - 1, PANEL_W, PANEL_ROWS - 1, 1'b1, 0);
      issue(CMD_DRAW, 0, 0, COORD_MAX, COORD_MAX, 1'b1, 0);
      issue(CMD_DRAW, COORD_MAX, 0, 0, COORD_MAX, 1'b1, 0);
      issue(CMD_DRAW, 10, 0, 10, COORD_MAX, 1'b1, 0);
      issue(CMD_DRAW, 0, 20, COORD_MAX, 20, 1'b1, 0);
      issue(CMD_DRAW, 90, 3, 2, 40, 1'b1, 0);
      read_byte(10);
      read_byte(2 * PANEL_W + 50);
      issue(CMD_DRAW, COORD_MAX, COORD_MAX, 0, 0, 1'b0, 0);
      read_byte(PANEL_W + 9);
      read_byte(STORE_BYTES);
      read_byte(RADDR_MAX);
      junk = '1;
      junk.cmd = CMD_UNUSED;
      send_word(junk);
      issue(CMD_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, RADDR_MAX);
      read_byte(10);
   endtask

   // Bulk random traffic; words with the unused code do not count.
   task automatic test_random_traffic();
      line_cmd_type c;
      int taken;
      taken = 0;
      while (taken < RANDOM_WORDS) begin
         c = random_word();
         send_word(c);
         if (c.cmd != CMD_UNUSED) taken++;
      end
   endtask

   // The receiver holds off for a long stretch while words keep coming, so the block
   // fills up and has to stall its input.
   task automatic test_output_backpressure();
      gaps_off        = 1'b1;
      rx_hold_request = PRESSURE_HOLD;
      repeat (PRESSURE_WORDS) send_word(random_word());
      gaps_off        = 1'b0;
   endtask

   // Receiver: stretches of no, light and heavy stalling, plus the long hold on request.
   initial begin : receiver
      int hold_left;
      int stretch_left;
      int ready_pct;
      hold_left    = 0;
      stretch_left = 0;
      ready_pct    = 100;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_request > 0) begin
            hold_left       = rx_hold_request;
            rx_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(50, 400);
               case ($urandom_range(0, 2))
                  0:       ready_pct = 100;
                  1:       ready_pct = 75;
                  default: ready_pct = 25;
               endcase
            end
            stretch_left--;
            rsp_tready = ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   // Compare each accepted response word with the oldest prediction.
   always @(posedge clock) begin : check_responses
      line_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word, expected none, got %h", $time, rsp_tdata);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[7:0] !== want.read_data) begin
               errors++;
               $display("%0t: read_data expected %h, got %h", $time, want.read_data,
                        rsp_tdata[7:0]);
            end
            if (rsp_tdata[15:8] !== want.pixels_drawn) begin
               errors++;
               $display("%0t: pixels_drawn expected %0d, got %0d", $time, want.pixels_drawn,
                        rsp_tdata[15:8]);
            end
         end
      end
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_contents();
      test_directed_lines();
      test_random_traffic();
      test_output_backpressure();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
